>>> rtl/multi_channel_timestamp_aligner_macros.svh
// ----------------------------------------------------------------------------
// Timestamp aligner assertion macros
// Shared forms for the concurrent checks of the aligner.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_TIMESTAMP_ALIGNER_MACROS_SVH
`define MULTI_CHANNEL_TIMESTAMP_ALIGNER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MCTA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MCTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define MCTA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mcta_pkg.sv
// ----------------------------------------------------------------------------
// Timestamp aligner package
// Request, result, slot storage and queue status types and shared constants.
// ----------------------------------------------------------------------------
package mcta_pkg;

   localparam int CHANNELS_DEFAULT = 4;
   localparam int QUEUE_DEPTH      = 2;
   localparam logic [31:0] TIMEOUT_RESET = 32'd100;

   typedef struct packed {
      logic [1:0]  channel;
      logic [31:0] stamp;
      logic [15:0] payload;
   } req_type;

   typedef struct packed {
      logic [1:0]  slot;
      logic        present;
      logic [31:0] slot_stamp;
      logic [15:0] slot_payload;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] stamp;
      logic [15:0] payload;
   } slot_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> rtl/multi_channel_timestamp_aligner.sv
// ----------------------------------------------------------------------------
// Multi-channel timestamp aligner
// Gathers stamped requests into one bundle slot per channel and emits each
// finished bundle as one result per slot.
// ----------------------------------------------------------------------------
// A request is taken every cycle while the two-entry bundle queue has room;
// the bundle it closes, if any, is in the queue at that same edge, and its
// results pass through the result register. The back end delivers one result
// per cycle while rsp_stall is low, CHANNELS results per bundle, set by the
// single slot walker that reads the queue head. Requests that close a bundle
// every time (for example the same channel repeatedly) fill the queue and
// wait on req_stall; requests that only fill slots are taken once per cycle.
module multi_channel_timestamp_aligner #(
   parameter int CHANNELS = mcta_pkg::CHANNELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  mcta_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mcta_pkg::rsp_type rsp_data
);

   mcta_pkg::queue_status_type q_status;
   logic                       push_valid;
   logic [CHANNELS-1:0]        push_mask;
   mcta_pkg::slot_entry_type   push_slots [CHANNELS];
   logic                       pop;
   logic [CHANNELS-1:0]        head_mask;
   mcta_pkg::slot_entry_type   head_slots [CHANNELS];

   mcta_front #(.CHANNELS(CHANNELS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .q_status    (q_status),
      .push_valid  (push_valid),
      .push_mask   (push_mask),
      .push_slots  (push_slots)
   );

   mcta_queue #(.CHANNELS(CHANNELS)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_mask  (push_mask),
      .push_slots (push_slots),
      .pop        (pop),
      .q_status   (q_status),
      .head_mask  (head_mask),
      .head_slots (head_slots)
   );

   mcta_back #(.CHANNELS(CHANNELS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_mask  (head_mask),
      .head_slots (head_slots),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

>>> rtl/mcta_front.sv
// ----------------------------------------------------------------------------
// Timestamp aligner front end
// Holds the open bundle, classifies each request and hands finished bundles
// to the queue.
// ----------------------------------------------------------------------------
module mcta_front #(
   parameter int CHANNELS = mcta_pkg::CHANNELS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [31:0]               csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mcta_pkg::req_type         req_data,
   input  mcta_pkg::queue_status_type q_status,
   output logic                      push_valid,
   output logic [CHANNELS-1:0]       push_mask,
   output mcta_pkg::slot_entry_type  push_slots [CHANNELS]
);

   logic [CHANNELS-1:0]      valid_ff, valid_in;
   logic [31:0]              start_ff, start_in;
   logic [31:0]              timeout_ff;
   mcta_pkg::slot_entry_type slots_ff [CHANNELS];
   mcta_pkg::slot_entry_type ins_slots [CHANNELS];

   logic [CHANNELS-1:0] hit;
   logic [CHANNELS-1:0] merged_valid;
   logic [31:0]         diff;
   logic                accept;
   logic                in_range;
   logic                taken;
   logic                empty;
   logic                timed_out;
   logic                flush_first;
   logic                full_now;
   logic                update;

   always_comb begin
      for (int k = 0; k < CHANNELS; k++) begin
         hit[k] = (int'(req_data.channel) == k);
         ins_slots[k] = hit[k] ? mcta_pkg::slot_entry_type'({req_data.stamp, req_data.payload})
                               : slots_ff[k];
      end
      req_stall    = q_status.full;
      accept       = req_valid && !q_status.full;
      in_range     = |hit;
      update       = accept && in_range;
      taken        = |(hit & valid_ff);
      empty        = ~|valid_ff;
      diff         = req_data.stamp - start_ff;
      timed_out    = !diff[31] && (diff > timeout_ff);
      flush_first  = taken || (!empty && timed_out);
      merged_valid = (flush_first ? '0 : valid_ff) | hit;
      full_now     = &merged_valid;

      push_valid = update && (flush_first || full_now);
      push_mask  = flush_first ? valid_ff : merged_valid;
      for (int k = 0; k < CHANNELS; k++) begin
         push_slots[k] = flush_first ? slots_ff[k] : ins_slots[k];
      end

      valid_in = valid_ff;
      start_in = start_ff;
      if (update) begin
         valid_in = (full_now && !flush_first) ? '0 : merged_valid;
         if (flush_first || empty) begin
            start_in = req_data.stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         start_ff   <= '0;
         timeout_ff <= mcta_pkg::TIMEOUT_RESET;
      end else begin
         valid_ff <= valid_in;
         start_ff <= start_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         for (int k = 0; k < CHANNELS; k++) begin
            slots_ff[k] <= ins_slots[k];
         end
      end
   end

endmodule

>>> rtl/mcta_queue.sv
// ----------------------------------------------------------------------------
// Timestamp aligner bundle queue
// Short first-in first-out store of finished bundles between front and back.
// ----------------------------------------------------------------------------
module mcta_queue #(
   parameter int CHANNELS = mcta_pkg::CHANNELS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  logic [CHANNELS-1:0]        push_mask,
   input  mcta_pkg::slot_entry_type   push_slots [CHANNELS],
   input  logic                       pop,
   output mcta_pkg::queue_status_type q_status,
   output logic [CHANNELS-1:0]        head_mask,
   output mcta_pkg::slot_entry_type   head_slots [CHANNELS]
);

   localparam int Depth = mcta_pkg::QUEUE_DEPTH;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   logic [CHANNELS-1:0]      mask_ff [Depth];
   mcta_pkg::slot_entry_type data_ff [Depth][CHANNELS];
   logic [PtrW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]          count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   always_comb begin
      q_status.full  = (count_ff == CntW'(Depth));
      q_status.empty = (count_ff == '0);
      do_push   = push_valid && !q_status.full;
      do_pop    = pop && !q_status.empty;
      head_mask = mask_ff[rd_ptr_ff];
      for (int k = 0; k < CHANNELS; k++) begin
         head_slots[k] = data_ff[rd_ptr_ff][k];
      end
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mask_ff[wr_ptr_ff] <= push_mask;
         for (int k = 0; k < CHANNELS; k++) begin
            data_ff[wr_ptr_ff][k] <= push_slots[k];
         end
      end
   end

endmodule

>>> rtl/mcta_back.sv
// ----------------------------------------------------------------------------
// Timestamp aligner back end
// Walks the head bundle one slot per unstalled cycle into the result register.
// ----------------------------------------------------------------------------
module mcta_back #(
   parameter int CHANNELS = mcta_pkg::CHANNELS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mcta_pkg::queue_status_type q_status,
   input  logic [CHANNELS-1:0]        head_mask,
   input  mcta_pkg::slot_entry_type   head_slots [CHANNELS],
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output mcta_pkg::rsp_type          rsp_data
);

   localparam int IdxW = $clog2(CHANNELS);

   logic [IdxW-1:0]   idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   mcta_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              load;
   logic              last_idx;
   logic              present;

   always_comb begin
      load     = !rsp_valid_ff || !rsp_stall;
      last_idx = (idx_ff == IdxW'(CHANNELS - 1));
      present  = head_mask[idx_ff];
      pop      = load && !q_status.empty && last_idx;

      rsp_data_in.slot         = 2'(idx_ff);
      rsp_data_in.present      = present;
      rsp_data_in.slot_stamp   = present ? head_slots[idx_ff].stamp : '0;
      rsp_data_in.slot_payload = present ? head_slots[idx_ff].payload : '0;
      rsp_data_in.last         = last_idx;

      rsp_valid_in = rsp_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         rsp_valid_in = !q_status.empty;
         if (!q_status.empty) begin
            idx_in = last_idx ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && !q_status.empty) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/mcta_checker.sv
// ----------------------------------------------------------------------------
// Timestamp aligner port checker
// Checks result ordering and framing as seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "multi_channel_timestamp_aligner_macros.svh"

module mcta_checker #(
   parameter int CHANNELS = mcta_pkg::CHANNELS_DEFAULT
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mcta_pkg::rsp_type rsp_data
);

   localparam logic [1:0] LastSlot = 2'(CHANNELS - 1);

   `MCTA_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid, "result valid after reset")

   `MCTA_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

   `MCTA_ASSERT_NEXT(a_slot_order, clock, reset, rsp_valid && !rsp_stall && !rsp_data.last, rsp_valid && (rsp_data.slot == 2'($past(rsp_data.slot) + 2'd1)), "bundle results not consecutive")

   `MCTA_ASSERT_SAME(a_empty_zero, clock, reset, rsp_valid && (!rsp_data.present || (rsp_data.last != (rsp_data.slot == LastSlot))), rsp_data.present && (rsp_data.slot_stamp == '0) && (rsp_data.slot_payload == '0) && 1'b0 || !rsp_data.present && (rsp_data.slot_stamp == '0) && (rsp_data.slot_payload == '0) && (rsp_data.last == (rsp_data.slot == LastSlot)), "empty slot not zero or last flag misplaced")

endmodule

bind multi_channel_timestamp_aligner mcta_checker #(.CHANNELS(CHANNELS)) u_mcta_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
